>>> hdl/cpi_pkg.sv
// Package for the calorimeter pulse integrator: field widths, register
// indexes, reset values and internal types.
// No dependencies; used by calorimeter_pulse_integrator_unit.
package cpi_pkg;

    localparam int TAG_W    = 6;
    localparam int PED_W    = 20;
    localparam int GAIN_W   = 16;
    localparam int SLOT_W   = 5;
    localparam int ADC_W    = 16;
    localparam int LEVEL_W  = 21;
    localparam int CFG_W    = 21;
    localparam int CFG_IDX_W = 3;
    localparam int ENERGY_W = 32;
    localparam int QNS_W    = 10;

    localparam int CHARGE_W = 22;
    localparam int SUM_W    = 27;
    localparam int PROD_W   = SUM_W + GAIN_W + 1;

    localparam logic [SLOT_W:0] SAMPLE_SLOTS = (SLOT_W + 1)'(32);
    localparam logic [QNS_W-1:0] QNS_PER_SLOT = QNS_W'(25);
    localparam int ROUND_SHIFT = 12;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W - 1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_SAMPLE = 3'd0,
        REG_MAX_SAMPLE = 3'd1,
        REG_ZS_ENABLE  = 3'd2,
        REG_ZS_LEVEL   = 3'd3,
        REG_BAD_CODE   = 3'd4
    } t_reg_idx;

    localparam logic [SLOT_W-1:0]  RST_MIN_SAMPLE = SLOT_W'(0);
    localparam logic [SLOT_W-1:0]  RST_MAX_SAMPLE = SLOT_W'(31);
    localparam logic [LEVEL_W-1:0] RST_ZS_LEVEL   = LEVEL_W'(160);
    localparam logic [ADC_W-1:0]   RST_BAD_CODE   = ADC_W'(65535);

    typedef struct packed {
        logic signed [SUM_W-1:0]    charge_sum;
        logic signed [CHARGE_W-1:0] peak_charge;
        logic [SLOT_W-1:0]          peak_slot;
        logic signed [CHARGE_W-1:0] previous_charge;
        logic                       bad_seen;
        logic                       above_level_seen;
    } t_win_state;

endpackage

>>> hdl/calorimeter_pulse_integrator_unit.sv
// Calorimeter pulse integrator: windowed charge sum, peak time and energy.
// Depends on cpi_pkg for widths, register indexes and the state type.
//
//  channel   direction  handshake                 payload
//  in        request    i_in_valid / o_in_stall   tag, good, pedestal, gain, slot, adc
//  out       result     o_out_valid / i_out_stall result_tag, energy, peak_time_qns
//  cfg       write      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One request per cycle is taken while o_in_stall is low; a hit is output after its
// last-slot request passes the input register, window update, gain multiply and rounding.
// Reset clears configuration to defaults, window state and all valid bits.
// An output stall backs up through the four stages; bubbles are absorbed,
// so requests keep flowing while a finished hit waits.
module calorimeter_pulse_integrator_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [cpi_pkg::TAG_W-1:0]            i_channel_tag,
    input  logic                                 i_channel_good,
    input  logic [cpi_pkg::PED_W-1:0]            i_pedestal,
    input  logic [cpi_pkg::GAIN_W-1:0]           i_gain,
    input  logic [cpi_pkg::SLOT_W-1:0]           i_sample_index,
    input  logic [cpi_pkg::ADC_W-1:0]            i_adc,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [cpi_pkg::TAG_W-1:0]            o_result_tag,
    output logic signed [cpi_pkg::ENERGY_W-1:0]  o_energy,
    output logic [cpi_pkg::QNS_W-1:0]            o_peak_time_qns,
    input  logic                                 i_cfg_we,
    input  logic [cpi_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [cpi_pkg::CFG_W-1:0]            i_cfg_data
);

    // configuration
    logic [cpi_pkg::SLOT_W-1:0]  r_min_sample;
    logic [cpi_pkg::SLOT_W-1:0]  r_max_sample;
    logic                        r_zs_enable;
    logic [cpi_pkg::LEVEL_W-1:0] r_zs_level;
    logic [cpi_pkg::ADC_W-1:0]   r_bad_code;

    // stage 1: input register
    logic                        r_v1;
    logic [cpi_pkg::TAG_W-1:0]   r_tag1;
    logic                        r_good1;
    logic [cpi_pkg::PED_W-1:0]   r_ped1;
    logic [cpi_pkg::GAIN_W-1:0]  r_gain1;
    logic [cpi_pkg::SLOT_W-1:0]  r_slot1;
    logic [cpi_pkg::ADC_W-1:0]   r_adc1;

    // window state
    cpi_pkg::t_win_state r_st;
    cpi_pkg::t_win_state n_st;

    // stage 2: hit capture
    logic                                 r_v2;
    logic [cpi_pkg::TAG_W-1:0]            r_tag2;
    logic [cpi_pkg::GAIN_W-1:0]           r_gain2;
    logic signed [cpi_pkg::SUM_W-1:0]     r_sum2;
    logic [cpi_pkg::QNS_W-1:0]            r_qns2;

    // stage 3: product
    logic                                 r_v3;
    logic [cpi_pkg::TAG_W-1:0]            r_tag3;
    logic signed [cpi_pkg::PROD_W-1:0]    r_prod3;
    logic [cpi_pkg::QNS_W-1:0]            r_qns3;

    // stage 4: output register
    logic                                 r_v4;
    logic [cpi_pkg::TAG_W-1:0]            r_tag4;
    logic signed [cpi_pkg::ENERGY_W-1:0]  r_energy4;
    logic [cpi_pkg::QNS_W-1:0]            r_qns4;

    logic rdy1, rdy2, rdy3, rdy4;
    logic take1, step1;

    logic                                 in_win;
    logic                                 win_start;
    logic                                 n_emit;
    logic signed [cpi_pkg::CHARGE_W-1:0]  charge;
    logic signed [cpi_pkg::CHARGE_W:0]    pair_sum;
    logic signed [cpi_pkg::SUM_W:0]       wide_sum;
    cpi_pkg::t_win_state                  base;
    logic signed [cpi_pkg::PROD_W-1:0]    n_prod;
    logic signed [cpi_pkg::PROD_W-1:0]    rounded;

    assign rdy4 = !r_v4 || !i_out_stall;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_in_stall = !rdy1;
    assign take1 = i_in_valid && rdy1;
    assign step1 = r_v1 && rdy2;

    always_comb begin
        in_win = ({1'b0, r_slot1} < cpi_pkg::SAMPLE_SLOTS)
              && (r_slot1 >= r_min_sample) && (r_slot1 <= r_max_sample);
        win_start = (r_slot1 == r_min_sample);
        base = win_start ? '0 : r_st;
        charge = $signed({2'b00, r_adc1, 4'b0000}) - $signed({2'b00, r_ped1});
        pair_sum = (cpi_pkg::CHARGE_W + 1)'(base.previous_charge)
                 + (cpi_pkg::CHARGE_W + 1)'(charge);
        n_st = base;
        if ((r_slot1 > r_min_sample)
            && (pair_sum > $signed({2'b00, r_zs_level}))) begin
            n_st.above_level_seen = 1'b1;
        end
        n_st.previous_charge = charge;
        if (r_adc1 == r_bad_code) begin
            n_st.bad_seen = 1'b1;
        end
        wide_sum = (cpi_pkg::SUM_W + 1)'(base.charge_sum)
                 + (cpi_pkg::SUM_W + 1)'(charge);
        if (!n_st.bad_seen) begin
            priority if (wide_sum > (cpi_pkg::SUM_W + 1)'(cpi_pkg::SUM_MAX)) begin
                n_st.charge_sum = cpi_pkg::SUM_MAX;
            end else if (wide_sum < (cpi_pkg::SUM_W + 1)'(cpi_pkg::SUM_MIN)) begin
                n_st.charge_sum = cpi_pkg::SUM_MIN;
            end else begin
                n_st.charge_sum = wide_sum[cpi_pkg::SUM_W-1:0];
            end
            if (charge > base.peak_charge) begin
                n_st.peak_charge = charge;
                n_st.peak_slot   = r_slot1;
            end
        end
        n_emit = in_win && (r_slot1 == r_max_sample) && !n_st.bad_seen && r_good1
              && !(r_zs_enable && !n_st.above_level_seen);
    end

    always_comb begin
        n_prod = cpi_pkg::PROD_W'(r_sum2) * cpi_pkg::PROD_W'($signed({1'b0, r_gain2}));
        rounded = r_prod3 + cpi_pkg::PROD_W'(2048);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_sample <= cpi_pkg::RST_MIN_SAMPLE;
            r_max_sample <= cpi_pkg::RST_MAX_SAMPLE;
            r_zs_enable  <= 1'b0;
            r_zs_level   <= cpi_pkg::RST_ZS_LEVEL;
            r_bad_code   <= cpi_pkg::RST_BAD_CODE;
        end else if (i_cfg_we) begin
            unique case (cpi_pkg::t_reg_idx'(i_cfg_idx))
                cpi_pkg::REG_MIN_SAMPLE: r_min_sample <= i_cfg_data[cpi_pkg::SLOT_W-1:0];
                cpi_pkg::REG_MAX_SAMPLE: r_max_sample <= i_cfg_data[cpi_pkg::SLOT_W-1:0];
                cpi_pkg::REG_ZS_ENABLE:  r_zs_enable  <= i_cfg_data[0];
                cpi_pkg::REG_ZS_LEVEL:   r_zs_level   <= i_cfg_data[cpi_pkg::LEVEL_W-1:0];
                cpi_pkg::REG_BAD_CODE:   r_bad_code   <= i_cfg_data[cpi_pkg::ADC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_st <= '0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (step1 && in_win) begin
                r_st <= n_st;
            end
            if (rdy2) begin
                r_v2 <= step1 && n_emit;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take1) begin
            r_tag1  <= i_channel_tag;
            r_good1 <= i_channel_good;
            r_ped1  <= i_pedestal;
            r_gain1 <= i_gain;
            r_slot1 <= i_sample_index;
            r_adc1  <= i_adc;
        end
        if (rdy2 && step1) begin
            r_tag2  <= r_tag1;
            r_gain2 <= r_gain1;
            r_sum2  <= n_st.charge_sum;
            r_qns2  <= cpi_pkg::QNS_W'(n_st.peak_slot) * cpi_pkg::QNS_PER_SLOT;
        end
        if (rdy3 && r_v2) begin
            r_tag3  <= r_tag2;
            r_prod3 <= n_prod;
            r_qns3  <= r_qns2;
        end
        if (rdy4 && r_v3) begin
            r_tag4    <= r_tag3;
            r_energy4 <= rounded[cpi_pkg::ROUND_SHIFT +: cpi_pkg::ENERGY_W];
            r_qns4    <= r_qns3;
        end
    end

    assign o_out_valid     = r_v4;
    assign o_result_tag    = r_tag4;
    assign o_energy        = r_energy4;
    assign o_peak_time_qns = r_qns4;

endmodule
